>>> hw/rtl/qra_pkg.sv
// Package for the quaternion rotation accumulator: widths, constants, the
// controller state and command types, and the product index tables.
// Used by qra_ctrl, qra_dp, the top level and the checker.
package qra_pkg;

    localparam int FRAC_BITS   = 14;
    localparam int Q_W         = 16;
    localparam int OUT_W       = 23;
    localparam int N_ENTRIES   = 9;
    localparam int IN_TDATA_W  = 4 * Q_W;
    localparam int OUT_TDATA_W = N_ENTRIES * OUT_W + 8 - ((N_ENTRIES * OUT_W) % 8);
    localparam int MAG_W       = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int MUL_W       = 33;
    localparam int HAM_W       = 34;
    localparam int NMAG_W      = 33;
    localparam int DIV_W       = 49;
    localparam int QUO_W       = 16;
    localparam int E_W         = 18;

    localparam logic [Q_W-1:0] Q_ONE = Q_W'(1 << FRAC_BITS);
    localparam logic [MAG_W-1:0] MAG_RESET = 16'd256;

    localparam logic [CFG_IDX_W-1:0] REG_PREMULTIPLY   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAGNIFICATION = 1'd1;

    // Sign of term k of product component i, bit i*4+k set means subtract.
    localparam logic [15:0] HAM_NEG = 16'h428E;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HAM,
        ST_NLOAD,
        ST_NORM,
        ST_SQR,
        ST_SQRT,
        ST_DIV_INIT,
        ST_DIV_STEP,
        ST_DIV_END,
        ST_MAT,
        ST_SCALE,
        ST_DONE
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_HAM_MUL,
        OP_HAM_ACC,
        OP_NLOAD,
        OP_NORM,
        OP_SQ_MUL,
        OP_SQ_ACC,
        OP_SQRT,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_DIV_END,
        OP_MAT_MUL,
        OP_MAT_ACC,
        OP_SC_RND,
        OP_SC_MUL,
        OP_SC_SAT,
        OP_OUT
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [4:0] idx;
    } cmd_t;

    typedef struct packed {
        logic zero;
        logic norm_ok;
        logic out_busy;
    } stat_t;

    // Operand pairs of the ten orientation products:
    // ww wx wy wz xx yy zz xy xz yz
    function automatic logic [1:0] mat_a(input logic [3:0] j);
        logic [1:0] r;
        unique case (j)
            4'd0, 4'd1, 4'd2, 4'd3: r = 2'd0;
            4'd4, 4'd7, 4'd8:       r = 2'd1;
            4'd5, 4'd9:             r = 2'd2;
            default:                r = 2'd3;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] mat_b(input logic [3:0] j);
        logic [1:0] r;
        unique case (j)
            4'd0:             r = 2'd0;
            4'd1, 4'd4:       r = 2'd1;
            4'd2, 4'd5, 4'd7: r = 2'd2;
            default:          r = 2'd3;
        endcase
        return r;
    endfunction

endpackage

>>> hw/rtl/qra_ctrl.sv
// Sequencer of the quaternion rotation accumulator: steps the datapath
// through product, normalize, square, root, divide, matrix and scale phases.
// Depends on qra_pkg.
module qra_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  qra_pkg::stat_t stat,
    output qra_pkg::cmd_t  cmd
);
    import qra_pkg::*;

    state_t     state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic [3:0] idx_reg, idx_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_HAM;
                    cnt_next   = '0;
                end
            end
            ST_HAM: begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) state_next = ST_NLOAD;
            end
            ST_NLOAD: state_next = ST_NORM;
            ST_NORM: begin
                cnt_next = '0;
                if (stat.zero) state_next = ST_MAT;
                else if (stat.norm_ok) state_next = ST_SQR;
            end
            ST_SQR: begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd7) begin
                    state_next = ST_SQRT;
                    cnt_next   = '0;
                end
            end
            ST_SQRT: begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    state_next = ST_DIV_INIT;
                    idx_next   = '0;
                end
            end
            ST_DIV_INIT: begin
                state_next = ST_DIV_STEP;
                cnt_next   = '0;
            end
            ST_DIV_STEP: begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd15) state_next = ST_DIV_END;
            end
            ST_DIV_END: begin
                cnt_next = '0;
                if (idx_reg == 4'd3) begin
                    state_next = ST_MAT;
                end else begin
                    idx_next   = idx_reg + 4'd1;
                    state_next = ST_DIV_INIT;
                end
            end
            ST_MAT: begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd19) begin
                    state_next = ST_SCALE;
                    cnt_next   = '0;
                    idx_next   = '0;
                end
            end
            ST_SCALE: begin
                if (cnt_reg == 5'd2) begin
                    cnt_next = '0;
                    if (idx_reg == 4'(N_ENTRIES - 1)) state_next = ST_DONE;
                    else idx_next = idx_reg + 4'd1;
                end else begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            ST_DONE: begin
                if (!stat.out_busy) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        cmd.op   = OP_NONE;
        cmd.idx  = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) cmd.op = OP_LOAD;
            end
            ST_HAM: begin
                cmd.op  = cnt_reg[0] ? OP_HAM_ACC : OP_HAM_MUL;
                cmd.idx = {1'b0, cnt_reg[4:1]};
            end
            ST_NLOAD: cmd.op = OP_NLOAD;
            ST_NORM:  cmd.op = OP_NORM;
            ST_SQR: begin
                cmd.op  = cnt_reg[0] ? OP_SQ_ACC : OP_SQ_MUL;
                cmd.idx = {3'b0, cnt_reg[2:1]};
            end
            ST_SQRT: begin
                cmd.op  = OP_SQRT;
                cmd.idx = cnt_reg;
            end
            ST_DIV_INIT: begin
                cmd.op  = OP_DIV_INIT;
                cmd.idx = {1'b0, idx_reg};
            end
            ST_DIV_STEP: cmd.op = OP_DIV_STEP;
            ST_DIV_END: begin
                cmd.op  = OP_DIV_END;
                cmd.idx = {1'b0, idx_reg};
            end
            ST_MAT: begin
                cmd.op  = cnt_reg[0] ? OP_MAT_ACC : OP_MAT_MUL;
                cmd.idx = {1'b0, cnt_reg[4:1]};
            end
            ST_SCALE: begin
                cmd.idx = {1'b0, idx_reg};
                unique case (cnt_reg[1:0])
                    2'd0:    cmd.op = OP_SC_RND;
                    2'd1:    cmd.op = OP_SC_MUL;
                    default: cmd.op = OP_SC_SAT;
                endcase
            end
            ST_DONE: begin
                if (!stat.out_busy) cmd.op = OP_OUT;
            end
            default: cmd.op = OP_NONE;
        endcase
    end

endmodule

>>> hw/rtl/qra_dp.sv
// Datapath of the quaternion rotation accumulator: orientation registers,
// one shared multiplier, root and divide loops, output register.
// Depends on qra_pkg; driven by qra_ctrl commands.
module qra_dp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  qra_pkg::cmd_t                     cmd,
    output qra_pkg::stat_t                    stat,
    input  logic [qra_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  logic                              cfg_we,
    input  logic [qra_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [qra_pkg::MAG_W-1:0]         cfg_data,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [qra_pkg::OUT_TDATA_W-1:0]   m_tdata
);
    import qra_pkg::*;

    logic                     premult_reg;
    logic [MAG_W-1:0]         magcfg_reg;
    logic signed [Q_W-1:0]    ori_reg [4];
    logic signed [Q_W-1:0]    rot_reg [4];
    logic signed [HAM_W-1:0]  ham_reg [4];
    logic [NMAG_W-1:0]        mag_reg [4];
    logic [3:0]               neg_reg;
    logic                     zero_reg;
    logic signed [63:0]       prod_reg;
    logic [63:0]              s_reg;
    logic [63:0]              res_reg;
    logic [DIV_W-1:0]         rem_reg;
    logic [DIV_W-1:0]         dsh_reg;
    logic [QUO_W-1:0]         quo_reg;
    logic signed [31:0]       pr_reg [10];
    logic signed [E_W-1:0]    e_reg;
    logic [OUT_W-1:0]         out_reg [N_ENTRIES];
    logic                     m_tvalid_reg;
    logic [OUT_TDATA_W-1:0]   m_tdata_reg;

    logic signed [MUL_W-1:0]     mul_a, mul_b;
    logic signed [2*MUL_W-1:0]   mul_p;
    logic [1:0]                  hi_, lk, ti;
    logic                        shr, shl;
    logic [63:0]                 sq_bit, sq_t;
    logic signed [31:0]          esum;
    logic signed [HAM_W-1:0]     ham_term;
    logic [QUO_W-2:0]            qv;
    logic [35:0]                 sc_abs;
    logic [27:0]                 sc_mag;
    logic [OUT_W-1:0]            sc_val;

    function automatic logic signed [E_W-1:0] rnd14(input logic signed [31:0] v);
        logic [31:0] m;
        logic [17:0] r;
        m = v[31] ? 32'(-v) : 32'(v);
        r = 18'((m + 32'(1 << (FRAC_BITS - 1))) >> FRAC_BITS);
        return v[31] ? -$signed(r) : $signed(r);
    endfunction

    assign hi_ = cmd.idx[3:2];
    assign lk  = cmd.idx[1:0];
    assign ti  = hi_ ^ lk;

    // Operand select for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            OP_HAM_MUL: begin
                mul_a = MUL_W'(premult_reg ? ori_reg[lk] : rot_reg[lk]);
                mul_b = MUL_W'(premult_reg ? rot_reg[ti] : ori_reg[ti]);
            end
            OP_SQ_MUL: begin
                mul_a = $signed({1'b0, mag_reg[lk][31:0]});
                mul_b = $signed({1'b0, mag_reg[lk][31:0]});
            end
            OP_MAT_MUL: begin
                mul_a = MUL_W'(ori_reg[mat_a(cmd.idx[3:0])]);
                mul_b = MUL_W'(ori_reg[mat_b(cmd.idx[3:0])]);
            end
            OP_SC_MUL: begin
                mul_a = MUL_W'(e_reg);
                mul_b = $signed({{(MUL_W - MAG_W){1'b0}}, magcfg_reg});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign ham_term = HAM_NEG[{hi_, lk}] ? -HAM_W'(prod_reg[HAM_W-1:0])
                                          : HAM_W'(prod_reg[HAM_W-1:0]);

    // Scale so the largest magnitude lands in [2^30, 2^31)
    assign shr = (|mag_reg[0][32:31]) | (|mag_reg[1][32:31]) |
                 (|mag_reg[2][32:31]) | (|mag_reg[3][32:31]);
    assign shl = !((|mag_reg[0][32:30]) | (|mag_reg[1][32:30]) |
                   (|mag_reg[2][32:30]) | (|mag_reg[3][32:30]));

    assign sq_bit = 64'h4000_0000_0000_0000 >> {cmd.idx, 1'b0};
    assign sq_t   = res_reg + sq_bit;

    always_comb begin
        unique case (cmd.idx[3:0])
            4'd0:    esum = pr_reg[0] + pr_reg[4] - pr_reg[5] - pr_reg[6];
            4'd1:    esum = (pr_reg[7] - pr_reg[3]) <<< 1;
            4'd2:    esum = (pr_reg[2] + pr_reg[8]) <<< 1;
            4'd3:    esum = (pr_reg[3] + pr_reg[7]) <<< 1;
            4'd4:    esum = pr_reg[0] - pr_reg[4] + pr_reg[5] - pr_reg[6];
            4'd5:    esum = (pr_reg[9] - pr_reg[1]) <<< 1;
            4'd6:    esum = (pr_reg[8] - pr_reg[2]) <<< 1;
            4'd7:    esum = (pr_reg[1] + pr_reg[9]) <<< 1;
            default: esum = pr_reg[0] - pr_reg[4] - pr_reg[5] + pr_reg[6];
        endcase
    end

    assign qv = (quo_reg > QUO_W'(Q_ONE)) ? Q_ONE[QUO_W-2:0] : quo_reg[QUO_W-2:0];

    // Round by 8 half away from zero, then clamp to the output range
    always_comb begin
        sc_abs = prod_reg[35] ? 36'(-prod_reg[35:0]) : prod_reg[35:0];
        sc_mag = 28'((sc_abs + 36'd128) >> 8);
        if (!prod_reg[35]) begin
            sc_val = (sc_mag > 28'((1 << (OUT_W - 1)) - 1)) ? {1'b0, {(OUT_W-1){1'b1}}}
                                                              : sc_mag[OUT_W-1:0];
        end else begin
            sc_val = (sc_mag > 28'(1 << (OUT_W - 1))) ? {1'b1, {(OUT_W-1){1'b0}}}
                                                        : OUT_W'(-sc_mag[OUT_W-1:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            premult_reg  <= 1'b1;
            magcfg_reg   <= MAG_RESET;
            m_tvalid_reg <= 1'b0;
            ori_reg[0]   <= Q_ONE;
            ori_reg[1]   <= '0;
            ori_reg[2]   <= '0;
            ori_reg[3]   <= '0;
            zero_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_PREMULTIPLY) premult_reg <= cfg_data[0];
                if (cfg_index == REG_MAGNIFICATION) magcfg_reg <= cfg_data;
            end
            if (cmd.op == OP_OUT) m_tvalid_reg <= 1'b1;
            else if (m_tready) m_tvalid_reg <= 1'b0;
            if (cmd.op == OP_NLOAD) begin
                zero_reg <= (ham_reg[0] == '0) && (ham_reg[1] == '0) &&
                            (ham_reg[2] == '0) && (ham_reg[3] == '0);
            end
            if (cmd.op == OP_DIV_END) begin
                ori_reg[lk] <= neg_reg[lk] ? -$signed({1'b0, qv}) : $signed({1'b0, qv});
            end
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_p[63:0];
        unique case (cmd.op)
            OP_LOAD: begin
                for (int i = 0; i < 4; i++) rot_reg[i] <= s_tdata[i*Q_W +: Q_W];
            end
            OP_HAM_ACC: begin
                ham_reg[hi_] <= ((lk == 2'd0) ? HAM_W'(0) : ham_reg[hi_]) + ham_term;
            end
            OP_NLOAD: begin
                for (int i = 0; i < 4; i++) begin
                    mag_reg[i] <= ham_reg[i][HAM_W-1] ? NMAG_W'(-ham_reg[i])
                                                      : NMAG_W'(ham_reg[i]);
                    neg_reg[i] <= ham_reg[i][HAM_W-1] != ham_reg[0][HAM_W-1];
                end
            end
            OP_NORM: begin
                for (int i = 0; i < 4; i++) begin
                    if (shr) mag_reg[i] <= mag_reg[i] >> 1;
                    else if (shl) mag_reg[i] <= mag_reg[i] << 1;
                end
            end
            OP_SQ_ACC: begin
                s_reg   <= ((lk == 2'd0) ? 64'd0 : s_reg) + prod_reg;
                res_reg <= '0;
            end
            OP_SQRT: begin
                if (s_reg >= sq_t) begin
                    s_reg   <= s_reg - sq_t;
                    res_reg <= (res_reg >> 1) + sq_bit;
                end else begin
                    res_reg <= res_reg >> 1;
                end
            end
            OP_DIV_INIT: begin
                rem_reg <= {2'b0, mag_reg[lk][31:0], 15'b0} + {17'b0, res_reg[31:0]};
                dsh_reg <= {1'b0, res_reg[31:0], 16'b0};
                quo_reg <= '0;
            end
            OP_DIV_STEP: begin
                if (rem_reg >= dsh_reg) begin
                    rem_reg <= rem_reg - dsh_reg;
                    quo_reg <= {quo_reg[QUO_W-2:0], 1'b1};
                end else begin
                    quo_reg <= {quo_reg[QUO_W-2:0], 1'b0};
                end
                dsh_reg <= dsh_reg >> 1;
            end
            OP_MAT_ACC: pr_reg[cmd.idx[3:0]] <= prod_reg[31:0];
            OP_SC_RND:  e_reg <= rnd14(esum);
            OP_SC_SAT:  out_reg[cmd.idx[3:0]] <= sc_val;
            OP_OUT: begin
                for (int j = 0; j < N_ENTRIES; j++) m_tdata_reg[j*OUT_W +: OUT_W] <= out_reg[j];
                m_tdata_reg[OUT_TDATA_W-1:N_ENTRIES*OUT_W] <=
                    (OUT_TDATA_W - N_ENTRIES*OUT_W)'(zero_reg);
            end
            default: begin
            end
        endcase
    end

    assign stat.zero     = zero_reg;
    assign stat.norm_ok  = !shr && !shl;
    assign stat.out_busy = m_tvalid_reg && !m_tready;
    assign m_tvalid      = m_tvalid_reg;
    assign m_tdata       = m_tdata_reg;

endmodule

>>> hw/rtl/quaternion_rotation_accumulator.sv
// Top level of the quaternion rotation accumulator.
// Joins qra_ctrl and qra_dp; depends on qra_pkg.
//
//  channel  | ports            | payload (lowest bit up)
//  ---------+------------------+-----------------------------------------
//  input    | s_tvalid/tready  | rot_w, rot_x, rot_y, rot_z
//  result   | m_tvalid/tready  | m00 m01 m02 m10 m11 m12 m20 m21 m22, zero_norm
//  config   | cfg_we           | index 0 premultiply, 1 magnification
//
// An item's time from accept to result is set by the 32-step root
// loop, four divides, the normalize shift and one shared multiplier.
// A zero-norm product skips the square, root and divide phases.
// Reset is synchronous, active low; orientation returns to identity.
// A result waits in the output register under m_tready stall while the
// next item is taken in and worked on.
module quaternion_rotation_accumulator (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [qra_pkg::IN_TDATA_W-1:0]      s_tdata,  // rot_w, rot_x, rot_y, rot_z
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [qra_pkg::OUT_TDATA_W-1:0]     m_tdata,  // m00..m22 (23b each), zero_norm
    input  logic                                cfg_we,
    input  logic [qra_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [qra_pkg::MAG_W-1:0]           cfg_data
);
    import qra_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    qra_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    qra_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

>>> hw/rtl/qra_checker.sv
// Port-level checks for the quaternion rotation accumulator, with the bind
// that attaches them to the top level. Depends on qra_pkg.
module qra_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [qra_pkg::OUT_TDATA_W-1:0]   m_tdata
);
    import qra_pkg::*;

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped under stall");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed under stall");

    // one item in work at a time
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item taken while another is in work");

    // a new result comes only out of a busy period
    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !$past(m_tvalid)) |-> !$past(s_tready))
        else $error("result without an item in work");

endmodule

bind quaternion_rotation_accumulator qra_checker u_qra_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
